// ===== hdl/binary_quadtree_block_counter_defines.svh =====
// Assertion macros for the binary quadtree block counter.
// Used inside modules that have clk and rst_n in scope; no other dependencies.
`ifndef BINARY_QUADTREE_BLOCK_COUNTER_DEFINES_SVH
`define BINARY_QUADTREE_BLOCK_COUNTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BQBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bqbc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define BQBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bqbc: next-cycle check failed");

`endif

// ===== hdl/bqbc_pkg.sv =====
// Shared types and constants for the binary quadtree block counter.
// No dependencies; the files that use it reference it by scoped names.
`default_nettype none

package bqbc_pkg;

  // Default largest image side in pixels
  localparam int SIDE_MAX_DEF = 64;

  // Field and register widths
  localparam int TALLY_W     = 13;
  localparam int SIDE_LOG2_W = 3;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RESET = 3'd6;
  localparam logic [TALLY_W-1:0]     MERGE_COST      = 13'd3;

  // Register index (paddr word bit)
  localparam logic REG_SIDE_LOG2 = 1'b0;

  // Read order within one block: base corner, then the three sub-block corners
  localparam logic [1:0] RD_BASE  = 2'd0;
  localparam logic [1:0] RD_RIGHT = 2'd1;
  localparam logic [1:0] RD_DOWN  = 2'd2;
  localparam logic [1:0] RD_DIAG  = 2'd3;

  // Sub-block offsets in units of half a block: {row, col}
  localparam logic NBR_OFF [3][2] = '{'{1'b0, 1'b1}, '{1'b1, 1'b0}, '{1'b1, 1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_k;
    logic       eval;
    logic       emit;
  } bqbc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_last;
    logic side_one;
    logic blk_last;
    logic lvl_last;
  } bqbc_status_t;

endpackage

`default_nettype wire

// ===== hdl/bqbc_intf.sv =====
// Stream interfaces for the pixel request and result channels.
// Depends on bqbc_pkg for the tally width.
`default_nettype none

interface bqbc_in_if;
  logic valid;
  logic ready;
  logic pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface bqbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bqbc_pkg::TALLY_W-1:0] zero_leaves;
  logic [bqbc_pkg::TALLY_W-1:0] one_leaves;
  modport source (output valid, output zero_leaves, output one_leaves, input ready);
  modport sink (input valid, input zero_leaves, input one_leaves, output ready);
endinterface

`default_nettype wire

// ===== hdl/bqbc_ctrl.sv =====
// Sequencer for load, quadtree merge reads, evaluation and result issue.
// Depends on bqbc_pkg for command and status types.
`default_nettype none

module bqbc_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    restart,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire bqbc_pkg::bqbc_status_t st,
  output bqbc_pkg::bqbc_cmd_t    cmd
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && st.load_last) begin
          k_nxt     = bqbc_pkg::RD_BASE;
          state_nxt = st.side_one ? S_EMIT : S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        cmd.rd_k  = k_r;
        k_nxt     = k_r + 2'd1;
        if (k_r == bqbc_pkg::RD_DIAG) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        k_nxt     = bqbc_pkg::RD_BASE;
        state_nxt = (st.blk_last && st.lvl_last) ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // requests past the last pixel are taken and dropped
        in_ready = 1'b1;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
    if (restart) begin
      state_nxt = S_LOAD;
      k_nxt     = bqbc_pkg::RD_BASE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      k_r     <= bqbc_pkg::RD_BASE;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqbc_datapath.sv =====
// Pixel/flag memory, block address counters, tallies and result register.
// Depends on bqbc_pkg and bqbc_intf; driven by bqbc_ctrl commands.
`default_nettype none

module bqbc_datapath #(
  parameter int MAX_LOG2 = 6
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 restart,
  input  wire  [bqbc_pkg::SIDE_LOG2_W-1:0]    eff_log2,
  input  wire                                 pixel_value,
  input  wire bqbc_pkg::bqbc_cmd_t            cmd,
  output bqbc_pkg::bqbc_status_t              st,
  bqbc_out_if.source                          out_chan
);

  localparam int AW    = 2 * MAX_LOG2;
  localparam int IW    = AW + 1;
  localparam int CW    = MAX_LOG2 + 1;
  localparam int LW    = $clog2(MAX_LOG2 + 1);
  localparam int DEPTH = 1 << AW;
  localparam int TW    = bqbc_pkg::TALLY_W;
  localparam int SIDE_LOG2_EXT = bqbc_pkg::SIDE_LOG2_W;

  // word: bit 1 merged flag, bit 0 pixel
  logic [1:0]    mem [DEPTH];
  logic [1:0]    rdata_r;

  logic [IW-1:0] pixel_index_r;
  logic [TW-1:0] zero_tally_r, one_tally_r;
  logic [CW-1:0] row_r, col_r;
  logic [LW-1:0] lvl_r;
  logic          rd_en_d_r;
  logic [1:0]    rd_k_d_r;
  logic          acc_px_r, acc_ok_r;
  logic          out_valid_r;
  logic [TW-1:0] zero_out_r, one_out_r;

  logic [CW-1:0] side_c, unit_c, half_c, col_n, row_n;
  logic [CW-1:0] row_k, col_k;
  logic [IW-1:0] total_m1;
  logic [AW-1:0] base_addr, rd_addr, wr_addr;
  logic [1:0]    wr_data;
  logic [1:0]    nbr_i;
  logic          wr_en, first_lvl, row_end, blk_ok;

  // Block geometry for the current level
  always_comb begin
    side_c    = CW'(1) << eff_log2;
    unit_c    = CW'(1) << lvl_r;
    half_c    = CW'(1) << (lvl_r - LW'(1));
    col_n     = col_r + unit_c;
    row_n     = row_r + unit_c;
    row_end   = (col_n == side_c);
    total_m1  = (IW'(1) << {eff_log2, 1'b0}) - IW'(1);
    first_lvl = (lvl_r == LW'(1));
  end

  assign st.load_last = (pixel_index_r == total_m1);
  assign st.side_one  = (eff_log2 == '0);
  assign st.blk_last  = row_end && (row_n == side_c);
  assign st.lvl_last  = (SIDE_LOG2_EXT'(lvl_r) == eff_log2);

  // Corner address of the sub-block being read
  always_comb begin
    nbr_i = cmd.rd_k - 2'd1;
    row_k = row_r;
    col_k = col_r;
    if (cmd.rd_k != bqbc_pkg::RD_BASE) begin
      if (bqbc_pkg::NBR_OFF[nbr_i][0]) row_k = row_r + half_c;
      if (bqbc_pkg::NBR_OFF[nbr_i][1]) col_k = col_r + half_c;
    end
    rd_addr   = (AW'(row_k) << eff_log2) | AW'(col_k);
    base_addr = (AW'(row_r) << eff_log2) | AW'(col_r);
  end

  // Last sub-block arrives in the evaluate cycle
  assign blk_ok = acc_ok_r && (first_lvl || rdata_r[1]) && (rdata_r[0] == acc_px_r);

  // Memory write select: pixel load or merged flag update
  always_comb begin
    wr_en   = cmd.load || cmd.eval;
    wr_addr = cmd.load ? pixel_index_r[AW-1:0] : base_addr;
    wr_data = cmd.load ? {1'b0, pixel_value} : {blk_ok, acc_px_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Gather base pixel and sub-block checks as read data returns
  always_ff @(posedge clk) begin
    if (rd_en_d_r) begin
      case (rd_k_d_r) inside
        bqbc_pkg::RD_BASE: begin
          acc_px_r <= rdata_r[0];
          acc_ok_r <= first_lvl || rdata_r[1];
        end
        bqbc_pkg::RD_RIGHT, bqbc_pkg::RD_DOWN: begin
          acc_ok_r <= acc_ok_r && (first_lvl || rdata_r[1]) && (rdata_r[0] == acc_px_r);
        end
        default: begin
        end
      endcase
    end
  end

  // Load index, tallies, read pipeline and block walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_index_r <= '0;
      zero_tally_r  <= '0;
      one_tally_r   <= '0;
      row_r         <= '0;
      col_r         <= '0;
      lvl_r         <= LW'(1);
      rd_en_d_r     <= 1'b0;
      rd_k_d_r      <= bqbc_pkg::RD_BASE;
    end else begin
      rd_en_d_r <= cmd.rd_en;
      rd_k_d_r  <= cmd.rd_k;
      if (restart) begin
        pixel_index_r <= '0;
        zero_tally_r  <= '0;
        one_tally_r   <= '0;
      end else if (cmd.load) begin
        pixel_index_r <= pixel_index_r + IW'(1);
        if (pixel_value) begin
          one_tally_r <= one_tally_r + TW'(1);
        end else begin
          zero_tally_r <= zero_tally_r + TW'(1);
        end
        if (st.load_last) begin
          row_r <= '0;
          col_r <= '0;
          lvl_r <= LW'(1);
        end
      end else if (cmd.eval) begin
        if (blk_ok) begin
          if (acc_px_r) begin
            one_tally_r <= one_tally_r - bqbc_pkg::MERGE_COST;
          end else begin
            zero_tally_r <= zero_tally_r - bqbc_pkg::MERGE_COST;
          end
        end
        if (!row_end) begin
          col_r <= col_n;
        end else begin
          col_r <= '0;
          if (st.blk_last) begin
            row_r <= '0;
            lvl_r <= lvl_r + LW'(1);
          end else begin
            row_r <= row_n;
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      zero_out_r <= zero_tally_r;
      one_out_r  <= one_tally_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.zero_leaves = zero_out_r;
  assign out_chan.one_leaves  = one_out_r;

endmodule

`default_nettype wire

// ===== hdl/binary_quadtree_block_counter.sv =====
// Binary quadtree block counter, top level. N = side*side pixels, one per cycle on load.
// Merge walks (N-1)/3 blocks, each read corner by corner on the single read port of the pixel memory
// and then evaluated; the result is registered and held valid until the receiver takes it.
// Synchronous active-low reset: side_log2 = 6, index and tallies zero, no result pending.
// Depends on bqbc_pkg, bqbc_intf, bqbc_ctrl, bqbc_datapath and the defines header.
`default_nettype none
`include "binary_quadtree_block_counter_defines.svh"

module binary_quadtree_block_counter #(
  parameter int SIDE_MAX = bqbc_pkg::SIDE_MAX_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  bqbc_in_if.sink                       in_chan,
  bqbc_out_if.source                    out_chan,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [bqbc_pkg::CFG_AW-1:0]   paddr,
  input  wire  [bqbc_pkg::CFG_DW-1:0]   pwdata,
  output logic [bqbc_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int FLOOR_LOG2 = $clog2(SIDE_MAX + 1) - 1;
  localparam int MAX_LOG2   = (FLOOR_LOG2 > 7) ? 7 : FLOOR_LOG2;
  localparam int SW         = bqbc_pkg::SIDE_LOG2_W;

  logic [SW-1:0] side_log2_r, eff_log2;
  logic          reg_hit, cfg_wr;

  bqbc_pkg::bqbc_cmd_t    cmd;
  bqbc_pkg::bqbc_status_t st;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[bqbc_pkg::CFG_AW-1] == bqbc_pkg::REG_SIDE_LOG2);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_log2_r <= bqbc_pkg::SIDE_LOG2_RESET;
    end else if (cfg_wr) begin
      side_log2_r <= pwdata[SW-1:0];
    end
  end

  assign prdata = reg_hit ? bqbc_pkg::CFG_DW'(side_log2_r) : '0;

  // Sides beyond the memory clamp to the largest that fits
  assign eff_log2 = (side_log2_r > SW'(MAX_LOG2)) ? SW'(MAX_LOG2) : side_log2_r;

  bqbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_wr),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  bqbc_datapath #(
    .MAX_LOG2 (MAX_LOG2)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (cfg_wr),
    .eff_log2    (eff_log2),
    .pixel_value (in_chan.pixel_value),
    .cmd         (cmd),
    .st          (st),
    .out_chan    (out_chan)
  );

  // No pixel request is taken while the merge is reading memory
  `BQBC_ASSERT_NOW(a_no_load_in_merge, cmd.rd_en, !in_chan.ready)
  // Evaluation follows the read of the diagonal sub-block
  `BQBC_ASSERT_NOW(a_eval_after_reads, cmd.eval,
                   $past(cmd.rd_en) && ($past(cmd.rd_k) == bqbc_pkg::RD_DIAG))
  // The final block of the top level issues the result next
  `BQBC_ASSERT_NEXT(a_emit_after_top, cmd.eval && st.blk_last && st.lvl_last && !cfg_wr,
                    cmd.emit)

endmodule

`default_nettype wire

// ===== tb/binary_quadtree_block_counter_test.sv =====
// Self-checking bench for binary_quadtree_block_counter: streams binary images, folds each
// image into quadtree leaf counts locally and compares every emitted result.
// Depends on bqbc_pkg, bqbc_intf and the block under test.
`default_nettype none

module binary_quadtree_block_counter_test;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IMG_MAX       = bqbc_pkg::SIDE_MAX_DEF * bqbc_pkg::SIDE_MAX_DEF;
  localparam int RANDOM_PIXELS = 600;
  localparam int MIN_IMAGES    = 12;
  localparam int PARTIAL_LOAD  = 16;

  // Image content styles
  localparam int STYLE_TREE    = 0;
  localparam int STYLE_FLIP    = 1;
  localparam int STYLE_NOISE   = 2;
  localparam int STYLE_UNIFORM = 3;
  localparam int STYLE_CHECKER = 4;
  localparam int STYLE_ZERO    = 5;
  localparam int STYLE_ONE     = 6;

  typedef struct packed {
    logic [bqbc_pkg::TALLY_W-1:0] zero_leaves;
    logic [bqbc_pkg::TALLY_W-1:0] one_leaves;
  } leaf_count_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bqbc_pkg::CFG_AW-1:0] paddr;
  logic [bqbc_pkg::CFG_DW-1:0] pwdata;
  logic [bqbc_pkg::CFG_DW-1:0] prdata;
  logic pready;

  bqbc_in_if  pixel_chan ();
  bqbc_out_if leaf_chan ();

  binary_quadtree_block_counter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pixel_chan),
    .out_chan (leaf_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Local copy of the block state
  bit                           img_pixels [IMG_MAX];
  bit                           merged_mark [IMG_MAX];
  logic [bqbc_pkg::SIDE_LOG2_W-1:0] side_cfg;
  int unsigned                  load_count;
  logic [bqbc_pkg::TALLY_W-1:0] zero_count;
  logic [bqbc_pkg::TALLY_W-1:0] one_count;

  leaf_count_t leaf_counts_due [$];
  bit          pixel_queue [$];
  bit          image_buf [IMG_MAX];

  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on;
  int          send_gap;
  int          out_stall;

  // Effective side: halve until it fits the largest image
  function automatic int unsigned image_side(logic [bqbc_pkg::SIDE_LOG2_W-1:0] lg);
    int unsigned s;
    s = 32'd1 << lg;
    while (s > bqbc_pkg::SIDE_MAX_DEF) s = s >> 1;
    return s;
  endfunction

  // Bottom-up merge; each merge removes three leaves of the block's value
  function automatic void fold_quadtree(int unsigned side);
    int unsigned unit, half, r, c, base, n;
    bit ok;
    for (int i = 0; i < side * side; i++) merged_mark[i] = 1'b1;
    for (unit = 2; unit <= side; unit = unit << 1) begin
      half = unit >> 1;
      for (r = 0; r < side; r += unit) begin
        for (c = 0; c < side; c += unit) begin
          base = r * side + c;
          if (merged_mark[base]) begin
            ok = 1'b1;
            for (int k = 0; k < 3; k++) begin
              n = (r + half * bqbc_pkg::NBR_OFF[k][0]) * side
                  + c + half * bqbc_pkg::NBR_OFF[k][1];
              if (!merged_mark[n] || img_pixels[n] != img_pixels[base]) ok = 1'b0;
            end
            if (!ok) merged_mark[base] = 1'b0;
            else if (img_pixels[base]) one_count = one_count - bqbc_pkg::MERGE_COST;
            else zero_count = zero_count - bqbc_pkg::MERGE_COST;
          end
        end
      end
    end
  endfunction

  // One accepted pixel; the last one of an image queues the leaf counts
  function automatic void take_pixel(bit px);
    int unsigned side, total;
    side  = image_side(side_cfg);
    total = side * side;
    if (load_count >= total) return;
    img_pixels[load_count] = px;
    if (px) one_count = one_count + bqbc_pkg::TALLY_W'(1);
    else zero_count = zero_count + bqbc_pkg::TALLY_W'(1);
    load_count++;
    if (load_count == total) begin
      fold_quadtree(side);
      leaf_counts_due.push_back('{zero_leaves: zero_count, one_leaves: one_count});
    end
  endfunction

  // Random block: either one fill or four sub-blocks
  function automatic void paint_block(int unsigned side, int unsigned r, int unsigned c,
                                      int unsigned sz);
    bit v;
    int unsigned h;
    if (sz == 1 || $urandom_range(0, 1) == 0) begin
      v = 1'($urandom_range(0, 1));
      for (int i = 0; i < sz; i++)
        for (int j = 0; j < sz; j++) image_buf[(r + i) * side + c + j] = v;
    end else begin
      h = sz >> 1;
      paint_block(side, r, c, h);
      paint_block(side, r, c + h, h);
      paint_block(side, r + h, c, h);
      paint_block(side, r + h, c + h, h);
    end
  endfunction

  // Fill image_buf and queue it, plus a few pixels past the end of the image
  function automatic void queue_image(int unsigned side, int style, int unsigned extra);
    bit fill;
    int unsigned spot;
    fill = 1'($urandom_range(0, 1));
    case (style) inside
      STYLE_TREE, STYLE_FLIP: begin
        paint_block(side, 0, 0, side);
        if (style == STYLE_FLIP) begin
          spot = $urandom_range(0, side * side - 1);
          image_buf[spot] = !image_buf[spot];
        end
      end
      default: begin
        for (int i = 0; i < side * side; i++) begin
          case (style)
            STYLE_NOISE:   image_buf[i] = 1'($urandom_range(0, 1));
            STYLE_UNIFORM: image_buf[i] = fill;
            STYLE_CHECKER: image_buf[i] = 1'(((i / side) ^ (i % side)) & 1);
            STYLE_ZERO:    image_buf[i] = 1'b0;
            default:       image_buf[i] = 1'b1;
          endcase
        end
      end
    endcase
    for (int i = 0; i < side * side; i++) pixel_queue.push_back(image_buf[i]);
    for (int i = 0; i < extra; i++) pixel_queue.push_back(1'($urandom_range(0, 1)));
  endfunction

  // Register write: setup then access cycle
  task automatic write_side_log2(logic [bqbc_pkg::SIDE_LOG2_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bqbc_pkg::REG_SIDE_LOG2, 2'b00};
    pwdata  <= bqbc_pkg::CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    side_cfg   = val;
    load_count = 0;
    zero_count = '0;
    one_count  = '0;
  endtask

  // Stimulus holds off until every queued request is sent and every result is back
  task automatic drain;
    while (pixel_queue.size() != 0 || pixel_chan.valid || leaf_counts_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_image(logic [bqbc_pkg::SIDE_LOG2_W-1:0] lg, int style,
                           int unsigned extra);
    write_side_log2(lg);
    queue_image(image_side(lg), style, extra);
    drain();
  endtask

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = !clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Pixel request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_chan.valid       <= 1'b0;
      pixel_chan.pixel_value <= 1'b0;
      send_gap               <= 0;
    end else begin
      if (pixel_chan.valid && pixel_chan.ready) take_pixel(pixel_chan.pixel_value);
      if (!pixel_chan.valid || pixel_chan.ready) begin
        if (send_gap != 0) begin
          send_gap         <= send_gap - 1;
          pixel_chan.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
          send_gap         <= $urandom_range(0, 14);
          pixel_chan.valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          pixel_chan.valid       <= 1'b1;
          pixel_chan.pixel_value <= pixel_queue.pop_front();
        end else begin
          pixel_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    leaf_count_t due;
    if (!rst_n) begin
      leaf_chan.ready <= 1'b0;
      out_stall       <= 0;
    end else begin
      if (leaf_chan.valid && leaf_chan.ready) begin
        if (leaf_counts_due.size() == 0) begin
          $display("%0t: unexpected result zero_leaves=%0d one_leaves=%0d", $time,
                   leaf_chan.zero_leaves, leaf_chan.one_leaves);
          error_count++;
        end else begin
          due = leaf_counts_due.pop_front();
          if (leaf_chan.zero_leaves !== due.zero_leaves) begin
            $display("%0t: zero_leaves expected %0d actual %0d", $time,
                     due.zero_leaves, leaf_chan.zero_leaves);
            error_count++;
          end
          if (leaf_chan.one_leaves !== due.one_leaves) begin
            $display("%0t: one_leaves expected %0d actual %0d", $time,
                     due.one_leaves, leaf_chan.one_leaves);
            error_count++;
          end
        end
      end
      if (out_stall != 0) begin
        out_stall       <= out_stall - 1;
        leaf_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall       <= $urandom_range(0, 14);
        leaf_chan.ready <= 1'b0;
      end else begin
        leaf_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL binary_quadtree_block_counter");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned pixels_sent;
    int unsigned images_sent;
    int unsigned pick;
    logic [bqbc_pkg::SIDE_LOG2_W-1:0] lg;
    int style;

    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    pixels_sent = 0;
    images_sent = 0;
    idle_on     = 1'b1;
    side_cfg    = bqbc_pkg::SIDE_LOG2_RESET;
    load_count  = 0;
    zero_count  = '0;
    one_count   = '0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Partial image at the reset setting; the next register write restarts loading
    for (int i = 0; i < PARTIAL_LOAD; i++) pixel_queue.push_back(1'($urandom_range(0, 1)));
    drain();

    // Directed: single pixel images, trailing input, small patterns
    run_image(3'd0, STYLE_ZERO, 0);
    run_image(3'd0, STYLE_ONE, 3);
    run_image(3'd1, STYLE_ONE, 0);
    run_image(3'd1, STYLE_ZERO, 1);
    run_image(3'd1, STYLE_CHECKER, 0);
    run_image(3'd2, STYLE_CHECKER, 0);

    // Oversized setting folds back to the largest side; partial load only
    write_side_log2(3'd7);
    for (int i = 0; i < PARTIAL_LOAD; i++) pixel_queue.push_back(1'($urandom_range(0, 1)));
    drain();

    // Random images, mostly small
    while (pixels_sent < RANDOM_PIXELS || images_sent < MIN_IMAGES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 11);
      if (pick == 0) lg = 3'd0;
      else if (pick < 4) lg = 3'd1;
      else if (pick < 8) lg = 3'd2;
      else if (pick < 11) lg = 3'd3;
      else lg = 3'd4;
      pick = $urandom_range(0, 9);
      if (pick < 6) style = STYLE_TREE;
      else if (pick < 8) style = STYLE_FLIP;
      else if (pick < 9) style = STYLE_NOISE;
      else style = STYLE_UNIFORM;
      run_image(lg, style, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      pixels_sent += image_side(lg) * image_side(lg);
      images_sent++;
    end

    // Closing stretch without idling
    idle_on = 1'b0;
    run_image(3'd3, STYLE_TREE, 0);
    run_image(3'd4, STYLE_FLIP, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && leaf_counts_due.size() == 0) begin
      $display("PASS binary_quadtree_block_counter");
    end else begin
      $display("FAIL binary_quadtree_block_counter");
    end
    $finish;
  end

endmodule

`default_nettype wire
